### hw/rtl/smgss_pkg.sv
// Shared constants, payload types and controller/datapath interface types.
package smgss_pkg;

	localparam int CAPACITY   = 1024;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TERM_PREV_NEXT = 2'd0,
		TERM_PREV_V    = 2'd1,
		TERM_V_NEXT    = 2'd2
	} term_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [63:0] gap_square_sum;
		logic [10:0] element_count;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic    load;
		logic    idx_clr;
		logic    idx_inc;
		logic    idx_dec;
		logic    idx_ld_top;
		logic    idx_ld_pos1;
		logic    rd;
		logic    prev_ld;
		logic    next_ld;
		logic    pos_ld;
		logic    mul_go;
		term_t   term;
		logic    acc_add;
		logic    acc_sub;
		logic    wr_up;
		logic    wr_down;
		logic    wr_v;
		logic    n_inc;
		logic    n_dec;
		logic    out_ld;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic is_delete;
		logic full;
		logic idx_at_n;
		logic idx_at_pos;
		logic rd_gt;
		logic rd_lt;
		logic rd_eq;
		logic has_prev;
		logic pos_lt_n;
		logic has_next_del;
		logic out_busy;
	} sts_t;

endpackage

### hw/rtl/sorted_multiset_gap_square_sum_top.sv
// Top level of the sorted multiset with running sum of squared neighbour gaps.
// Each transfer on req carries an insert (operation 0) or a delete of one copy
// (operation 1); every item yields exactly one transfer on rsp with the sum of
// squared gaps between neighbouring held values, the element count and a status
// (0 done, 1 insert refused as the store is full, 2 delete of an absent value;
// refusals leave the state untouched). Values are kept in ascending order in a
// single-port-read, single-port-write memory of CAPACITY entries. Items are
// handled one at a time: req_ready is high only while the block is idle. An
// item passes through a linear search (one memory read plus one compare per
// element passed), up to three multiply/accumulate pairs for the gap terms,
// and a shift of the elements behind the insert or delete point (one memory
// read plus one write per element moved). The result sits in an output
// register, so a waiting rsp does not hold up the work on an item until the
// result is ready to be loaded. No clearing pass is needed after reset: only
// entries below the element count are ever read.
module sorted_multiset_gap_square_sum_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  smgss_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output smgss_pkg::rsp_t   rsp
);

	// Command and status bundles between the sequencer and the datapath
	smgss_pkg::cmd_t cmd;
	smgss_pkg::sts_t sts;

	smgss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	smgss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// A refused insert reports a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == smgss_pkg::ST_FULL)
			|-> (rsp.element_count == 11'(smgss_pkg::CAPACITY)))
		else $error("full status with count below capacity");

endmodule

### hw/rtl/smgss_dp.sv
// Datapath: sorted value memory, scan and shift indices, gap multiplier, sum and result register.
module smgss_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  smgss_pkg::req_t    req,
	input  smgss_pkg::cmd_t    cmd,
	output smgss_pkg::sts_t    sts,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output smgss_pkg::rsp_t    rsp
);

	logic [smgss_pkg::VALUE_BITS-1:0]   mem [smgss_pkg::CAPACITY];
	logic                               op_q;
	logic [smgss_pkg::VALUE_BITS-1:0]   v_q;
	logic [smgss_pkg::VALUE_BITS-1:0]   prev_q;
	logic [smgss_pkg::VALUE_BITS-1:0]   next_q;
	logic [smgss_pkg::VALUE_BITS-1:0]   rd_q;
	logic [smgss_pkg::CNT_W-1:0]        n_q;
	logic [smgss_pkg::CNT_W-1:0]        idx_q;
	logic [smgss_pkg::CNT_W-1:0]        pos_q;
	logic [63:0]                        sum_q;
	logic [2*smgss_pkg::VALUE_BITS-1:0] prod_s1;

	logic [smgss_pkg::VALUE_BITS-1:0]   lo;
	logic [smgss_pkg::VALUE_BITS-1:0]   hi;
	logic [smgss_pkg::VALUE_BITS-1:0]   diff;
	logic                               we;
	logic [smgss_pkg::CNT_W-1:0]        waddr;
	logic [smgss_pkg::VALUE_BITS-1:0]   wdata;
	logic [smgss_pkg::CNT_W:0]          pos_p1;

	assign pos_p1 = {1'b0, pos_q} + 1'b1;

	always_comb begin
		sts.is_delete    = (op_q == smgss_pkg::OP_DELETE);
		sts.full         = (n_q == smgss_pkg::CNT_W'(smgss_pkg::CAPACITY));
		sts.idx_at_n     = (idx_q == n_q);
		sts.idx_at_pos   = (idx_q == pos_q);
		sts.rd_gt        = (rd_q > v_q);
		sts.rd_lt        = (rd_q < v_q);
		sts.rd_eq        = (rd_q == v_q);
		sts.has_prev     = (pos_q != '0);
		sts.pos_lt_n     = (pos_q < n_q);
		sts.has_next_del = (pos_p1 < {1'b0, n_q});
		sts.out_busy     = rsp_valid && !rsp_ready;
	end

	// Gap operands
	always_comb begin
		case (cmd.term)
			smgss_pkg::TERM_PREV_NEXT: begin
				lo = prev_q;
				hi = next_q;
			end
			smgss_pkg::TERM_PREV_V: begin
				lo = prev_q;
				hi = v_q;
			end
			smgss_pkg::TERM_V_NEXT: begin
				lo = v_q;
				hi = next_q;
			end
			default: begin
				lo = prev_q;
				hi = next_q;
			end
		endcase
		diff = hi - lo;
	end

	always_comb begin
		we    = cmd.wr_up || cmd.wr_down || cmd.wr_v;
		waddr = pos_q;
		wdata = rd_q;
		if (cmd.wr_up) begin
			waddr = idx_q + 1'b1;
		end else if (cmd.wr_down) begin
			waddr = idx_q - 1'b1;
		end else if (cmd.wr_v) begin
			wdata = v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[idx_q[smgss_pkg::IDX_W-1:0]];
		end
		if (we) begin
			mem[waddr[smgss_pkg::IDX_W-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.operation;
			v_q  <= req.value[smgss_pkg::VALUE_BITS-1:0];
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_ld_top) begin
			idx_q <= n_q - 1'b1;
		end else if (cmd.idx_ld_pos1) begin
			idx_q <= pos_p1[smgss_pkg::CNT_W-1:0];
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.pos_ld) begin
			pos_q <= idx_q;
		end
		if (cmd.prev_ld) begin
			prev_q <= rd_q;
		end
		if (cmd.next_ld) begin
			next_q <= rd_q;
		end
		if (cmd.mul_go) begin
			prod_s1 <= diff * diff;
		end
		if (cmd.out_ld) begin
			rsp.gap_square_sum <= sum_q;
			rsp.element_count  <= 11'(n_q);
			rsp.status         <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			sum_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cmd.n_inc) begin
				n_q <= n_q + 1'b1;
			end else if (cmd.n_dec) begin
				n_q <= n_q - 1'b1;
			end
			if (cmd.acc_add) begin
				sum_q <= sum_q + 64'(prod_s1);
			end else if (cmd.acc_sub) begin
				sum_q <= sum_q - 64'(prod_s1);
			end
			if (cmd.out_ld) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= smgss_pkg::CNT_W'(smgss_pkg::CAPACITY))
		else $error("element count above capacity");
	a_grow_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.n_inc |-> (n_q < smgss_pkg::CNT_W'(smgss_pkg::CAPACITY)))
		else $error("insert into full store");
	a_shrink_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.n_dec |-> (n_q != '0))
		else $error("delete from empty store");
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_up |-> (idx_q < n_q))
		else $error("upward shift past the last element");

endmodule

### hw/rtl/smgss_ctrl.sv
// Controller: sequences scan, gap arithmetic, shift and result hand-off.
module smgss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  smgss_pkg::sts_t   sts,
	output smgss_pkg::cmd_t   cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_I_TEST, S_I_CMP, S_D_TEST, S_D_CMP, S_D_NTEST, S_D_NCAP,
		S_MUL, S_ACC, S_SH_INIT, S_I_SH_RD, S_I_SH_WR, S_WRV, S_D_SH_TEST,
		S_D_SH_WR, S_FIN
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [1:0]          t_q;
	logic [1:0]          t_d;
	smgss_pkg::status_t  stat_q;
	smgss_pkg::status_t  stat_d;
	logic                term_en;
	logic                term_sub;
	smgss_pkg::term_t    term_sel;
	logic                last_term;

	assign last_term = (t_q == 2'd2);

	// Select the next squared gap to fold into the sum
	always_comb begin
		term_en  = 1'b0;
		term_sub = 1'b0;
		term_sel = smgss_pkg::TERM_PREV_NEXT;
		case (t_q)
			2'd0: begin
				if (sts.is_delete) begin
					term_en  = sts.has_prev;
					term_sub = 1'b1;
					term_sel = smgss_pkg::TERM_PREV_V;
				end else begin
					term_en  = sts.has_prev && sts.pos_lt_n;
					term_sub = 1'b1;
					term_sel = smgss_pkg::TERM_PREV_NEXT;
				end
			end
			2'd1: begin
				if (sts.is_delete) begin
					term_en  = sts.has_next_del;
					term_sub = 1'b1;
					term_sel = smgss_pkg::TERM_V_NEXT;
				end else begin
					term_en  = sts.has_prev;
					term_sel = smgss_pkg::TERM_PREV_V;
				end
			end
			2'd2: begin
				if (sts.is_delete) begin
					term_en  = sts.has_prev && sts.has_next_del;
					term_sel = smgss_pkg::TERM_PREV_NEXT;
				end else begin
					term_en  = sts.pos_lt_n;
					term_sel = smgss_pkg::TERM_V_NEXT;
				end
			end
			default: begin
				term_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		t_d        = t_q;
		stat_d     = stat_q;
		cmd        = '0;
		cmd.term   = term_sel;
		cmd.status = stat_q;
		req_ready  = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				t_d    = 2'd0;
				stat_d = smgss_pkg::ST_DONE;
				if (sts.is_delete) begin
					state_d = S_D_TEST;
				end else if (sts.full) begin
					stat_d  = smgss_pkg::ST_FULL;
					state_d = S_FIN;
				end else begin
					state_d = S_I_TEST;
				end
			end
			S_I_TEST: begin
				if (sts.idx_at_n) begin
					cmd.pos_ld = 1'b1;
					state_d    = S_MUL;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_I_CMP;
				end
			end
			S_I_CMP: begin
				if (sts.rd_gt) begin
					cmd.pos_ld  = 1'b1;
					cmd.next_ld = 1'b1;
					state_d     = S_MUL;
				end else begin
					cmd.prev_ld = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = S_I_TEST;
				end
			end
			S_D_TEST: begin
				if (sts.idx_at_n) begin
					stat_d  = smgss_pkg::ST_ABSENT;
					state_d = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_D_CMP;
				end
			end
			S_D_CMP: begin
				if (sts.rd_lt) begin
					cmd.prev_ld = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = S_D_TEST;
				end else if (sts.rd_eq) begin
					cmd.pos_ld  = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = S_D_NTEST;
				end else begin
					stat_d  = smgss_pkg::ST_ABSENT;
					state_d = S_FIN;
				end
			end
			S_D_NTEST: begin
				if (sts.idx_at_n) begin
					state_d = S_MUL;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_D_NCAP;
				end
			end
			S_D_NCAP: begin
				cmd.next_ld = 1'b1;
				state_d     = S_MUL;
			end
			S_MUL: begin
				if (term_en) begin
					cmd.mul_go = 1'b1;
					state_d    = S_ACC;
				end else if (last_term) begin
					state_d = S_SH_INIT;
				end else begin
					t_d = t_q + 1'b1;
				end
			end
			S_ACC: begin
				cmd.acc_sub = term_sub;
				cmd.acc_add = !term_sub;
				if (last_term) begin
					state_d = S_SH_INIT;
				end else begin
					t_d     = t_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_SH_INIT: begin
				if (sts.is_delete) begin
					cmd.idx_ld_pos1 = 1'b1;
					state_d         = S_D_SH_TEST;
				end else if (!sts.pos_lt_n) begin
					state_d = S_WRV;
				end else begin
					cmd.idx_ld_top = 1'b1;
					state_d        = S_I_SH_RD;
				end
			end
			S_I_SH_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_I_SH_WR;
			end
			S_I_SH_WR: begin
				cmd.wr_up = 1'b1;
				if (sts.idx_at_pos) begin
					state_d = S_WRV;
				end else begin
					cmd.idx_dec = 1'b1;
					state_d     = S_I_SH_RD;
				end
			end
			S_WRV: begin
				cmd.wr_v  = 1'b1;
				cmd.n_inc = 1'b1;
				state_d   = S_FIN;
			end
			S_D_SH_TEST: begin
				if (sts.idx_at_n) begin
					cmd.n_dec = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_D_SH_WR;
				end
			end
			S_D_SH_WR: begin
				cmd.wr_down = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_D_SH_TEST;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q     <= 2'd0;
			stat_q  <= smgss_pkg::ST_DONE;
		end else begin
			state_q <= state_d;
			t_q     <= t_d;
			stat_q  <= stat_d;
		end
	end

	a_fin_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (stat_q == smgss_pkg::ST_DONE || stat_q == smgss_pkg::ST_FULL
			|| stat_q == smgss_pkg::ST_ABSENT))
		else $error("result loaded with undefined status");
	a_no_store_on_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_up || cmd.wr_down || cmd.wr_v) |-> (stat_q == smgss_pkg::ST_DONE))
		else $error("memory written on a refused item");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_CHK))
		else $error("accepted item not taken into the check state");

endmodule
